// File: design/tcpfd_pkg.sv
// Shared types and constants for the time code pulse frame decoder.
package tcpfd_pkg;

    localparam int PULSE_TIME_W = 32;
    localparam int LIMIT_W = 16;
    localparam int SYMBOL_W = 3;
    localparam int FRAME_OUT_W = 60;
    localparam int FAILED_W = 4;
    localparam int MARKER_COUNT_W = 6;

    localparam int DEFAULT_HISTORY_DEPTH = 10;
    localparam int DEFAULT_FRAME_BITS = 60;

    localparam logic [MARKER_COUNT_W-1:0] NEEDED_MARKERS = MARKER_COUNT_W'(6);
    localparam logic [MARKER_COUNT_W-1:0] MARKER_COUNT_MAX = '1;

    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RESET = LIMIT_W'(100);
    localparam logic [LIMIT_W-1:0] ZERO_LIMIT_RESET = LIMIT_W'(400);
    localparam logic [LIMIT_W-1:0] ONE_LIMIT_RESET = LIMIT_W'(700);
    localparam logic [LIMIT_W-1:0] MARKER_LIMIT_RESET = LIMIT_W'(900);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_LIMIT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_LIMIT = 2'd3;

    typedef enum logic [SYMBOL_W-1:0] {
        SYM_ZERO = 3'd0,
        SYM_ONE = 3'd1,
        SYM_MARKER = 3'd2,
        SYM_ERROR = 3'd3,
        SYM_BOUNDARY = 3'd4
    } symbol_t;

    typedef struct packed {
        logic [PULSE_TIME_W-1:0] pulse_start;
        logic [PULSE_TIME_W-1:0] pulse_end;
    } pulse_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic frame_valid;
        logic [FRAME_OUT_W-1:0] frame_bits;
        logic [PULSE_TIME_W-1:0] frame_time;
        logic resync;
        logic [FAILED_W-1:0] failed_frames;
    } result_t;

endpackage

// File: design/time_code_pulse_frame_decoder_unit.sv
// Top level of the time code pulse frame decoder.
//
// Classifies each received low pulse (start and end timestamps in ms) by its
// width as a zero bit, one bit, position marker or width error, assembles
// frames of FRAME_BITS bits first bit highest, and reports a frame boundary on
// the second marker in a row when exactly six markers, a full bit count and no
// bad bits were seen. A frame that runs past FRAME_BITS bits is dropped and the
// decoder resynchronizes. The last HISTORY_DEPTH frame outcomes (good or
// failed) are kept in a ring; the failure total comes with every result,
// capped at 15. Rate: one pulse beat per clock cycle while the result port
// is not stalled. Each beat is registered in the input register and then
// moves to the result register once that register is empty or being taken;
// the single decode and update pass lies between those registers.
// While a result is stalled, one more pulse is taken and held in the input
// register. The four width limits reset to 100, 400, 700 and 900 ms and are
// written through the cfg port; the user must do so only while the decoder
// is idle, which the block itself does not enforce. No clearing pass runs
// after reset.
module time_code_pulse_frame_decoder_unit #(
    parameter int HISTORY_DEPTH = tcpfd_pkg::DEFAULT_HISTORY_DEPTH,
    parameter int FRAME_BITS = tcpfd_pkg::DEFAULT_FRAME_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic pulse_valid,
    output logic pulse_stall,
    input  tcpfd_pkg::pulse_t pulse,
    output logic result_valid,
    input  logic result_stall,
    output tcpfd_pkg::result_t result,
    input  logic cfg_we,
    input  logic [tcpfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcpfd_pkg::LIMIT_W-1:0] cfg_data
);
    import tcpfd_pkg::*;

    // Bit position runs 1..FRAME_BITS+1 before a resync check
    localparam int PLACE_W = $clog2(FRAME_BITS + 2);
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [PLACE_W-1:0] PLACE_FULL = PLACE_W'(FRAME_BITS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    // Width limits
    logic [LIMIT_W-1:0] short_limit_reg;
    logic [LIMIT_W-1:0] zero_limit_reg;
    logic [LIMIT_W-1:0] one_limit_reg;
    logic [LIMIT_W-1:0] marker_limit_reg;

    // Input stage
    logic pulse_valid_reg, pulse_valid_next;
    pulse_t pulse_reg;
    logic pulse_accept;
    logic advance;

    // Result stage
    logic result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    // Frame assembly state
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [PLACE_W-1:0] place_reg, place_next;
    logic [MARKER_COUNT_W-1:0] marker_count_reg, marker_count_next;
    logic prev_marker_reg, prev_marker_next;
    logic bad_seen_reg, bad_seen_next;
    logic [FRAME_BITS-1:0] good_frame_reg, good_frame_next;
    logic [PULSE_TIME_W-1:0] good_time_reg, good_time_next;

    // Outcome history
    logic [HISTORY_DEPTH-1:0] ring_reg, ring_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [COUNT_W-1:0] fail_count_reg, fail_count_next;

    // Decode intermediates
    logic [PULSE_TIME_W-1:0] width;
    logic below_short, below_zero, below_one, below_marker;
    logic is_error;
    logic boundary_hit;
    logic [FRAME_BITS-1:0] place_mask;
    logic log_en, log_fail;
    logic frame_valid, resync;
    symbol_t symbol;
    logic [5:0] count_ext;

    // Handshake: the input register frees up when its beat moves into the
    // result register, which happens whenever the result register is empty or
    // being taken in this cycle.
    assign pulse_accept = pulse_valid && !pulse_stall;
    assign advance = pulse_valid_reg && (!result_valid_reg || !result_stall);
    assign pulse_stall = pulse_valid_reg && result_valid_reg && result_stall;

    always_comb
    begin
        pulse_valid_next = pulse_valid_reg;
        if (pulse_accept)
        begin
            pulse_valid_next = 1'b1;
        end
        else if (advance)
        begin
            pulse_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Width classification. Limits are tested in their listed order, so a
    // limit set out of order simply shadows the ones after it.
    assign width = pulse_reg.pulse_end - pulse_reg.pulse_start;
    assign below_short = width < PULSE_TIME_W'(short_limit_reg);
    assign below_zero = width < PULSE_TIME_W'(zero_limit_reg);
    assign below_one = width < PULSE_TIME_W'(one_limit_reg);
    assign below_marker = width < PULSE_TIME_W'(marker_limit_reg);
    assign is_error = below_short || (!below_one && !below_zero && !below_marker);

    // Boundary: a second marker in a row closing a clean, full frame
    assign boundary_hit = prev_marker_reg && (marker_count_reg == NEEDED_MARKERS) &&
                          (place_reg == PLACE_FULL) && !bad_seen_reg;

    // One-hot mask of the word bit that the current bit position fills;
    // position 1 is the top bit.
    always_comb
    begin
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            place_mask[i] = (place_reg == PLACE_W'(FRAME_BITS - i));
        end
    end

    // Frame state update for one pulse
    always_comb
    begin
        shift_next = shift_reg;
        place_next = place_reg;
        marker_count_next = marker_count_reg;
        prev_marker_next = prev_marker_reg;
        bad_seen_next = bad_seen_reg;
        good_frame_next = good_frame_reg;
        good_time_next = good_time_reg;
        frame_valid = 1'b0;
        resync = 1'b0;
        log_en = 1'b0;
        log_fail = 1'b0;
        symbol = SYM_MARKER;

        if (is_error)
        begin
            // Take a bit position with a zero, flag the frame as damaged
            symbol = SYM_ERROR;
            place_next = place_reg + 1'b1;
            bad_seen_next = 1'b1;
            prev_marker_next = 1'b0;
        end
        else if (below_zero)
        begin
            symbol = SYM_ZERO;
            place_next = place_reg + 1'b1;
            prev_marker_next = 1'b0;
        end
        else if (below_one)
        begin
            symbol = SYM_ONE;
            shift_next = shift_reg | place_mask;
            place_next = place_reg + 1'b1;
            prev_marker_next = 1'b0;
        end
        else if (boundary_hit)
        begin
            // Latch the finished frame and start a new one
            symbol = SYM_BOUNDARY;
            frame_valid = 1'b1;
            good_frame_next = shift_reg;
            good_time_next = pulse_reg.pulse_start;
            log_en = 1'b1;
            shift_next = '0;
            place_next = PLACE_W'(1);
            marker_count_next = '0;
            prev_marker_next = 1'b0;
            bad_seen_next = 1'b0;
        end
        else
        begin
            symbol = SYM_MARKER;
            place_next = place_reg + 1'b1;
            if (marker_count_reg != MARKER_COUNT_MAX)
            begin
                marker_count_next = marker_count_reg + 1'b1;
            end
            prev_marker_next = 1'b1;
        end

        // Overrun: log a failed frame and drop everything gathered so far
        if (place_next > PLACE_FULL)
        begin
            resync = 1'b1;
            log_en = 1'b1;
            log_fail = 1'b1;
            shift_next = '0;
            place_next = PLACE_W'(1);
            marker_count_next = '0;
            prev_marker_next = 1'b0;
            bad_seen_next = 1'b0;
        end
    end

    // Outcome ring with a running failure total: swap the old entry's
    // contribution for the new one instead of recounting the ring.
    always_comb
    begin
        ring_next = ring_reg;
        slot_next = slot_reg;
        fail_count_next = fail_count_reg;
        if (log_en)
        begin
            ring_next[slot_reg] = log_fail;
            fail_count_next = fail_count_reg - COUNT_W'(ring_reg[slot_reg])
                              + COUNT_W'(log_fail);
            slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        end
    end

    assign count_ext = 6'(fail_count_next);

    always_comb
    begin
        result_next.symbol = symbol;
        result_next.frame_valid = frame_valid;
        result_next.frame_bits = FRAME_OUT_W'(good_frame_next);
        result_next.frame_time = good_time_next;
        result_next.resync = resync;
        result_next.failed_frames = (count_ext > 6'd15) ? 4'd15 : count_ext[3:0];
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            short_limit_reg <= SHORT_LIMIT_RESET;
            zero_limit_reg <= ZERO_LIMIT_RESET;
            one_limit_reg <= ONE_LIMIT_RESET;
            marker_limit_reg <= MARKER_LIMIT_RESET;
            shift_reg <= '0;
            place_reg <= PLACE_W'(1);
            marker_count_reg <= '0;
            prev_marker_reg <= 1'b0;
            bad_seen_reg <= 1'b0;
            good_frame_reg <= '0;
            good_time_reg <= '0;
            ring_reg <= '1;
            slot_reg <= '0;
            fail_count_reg <= COUNT_W'(HISTORY_DEPTH);
        end
        else
        begin
            pulse_valid_reg <= pulse_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SHORT_LIMIT:  short_limit_reg <= cfg_data;
                    CFG_ZERO_LIMIT:   zero_limit_reg <= cfg_data;
                    CFG_ONE_LIMIT:    one_limit_reg <= cfg_data;
                    CFG_MARKER_LIMIT: marker_limit_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (advance)
            begin
                shift_reg <= shift_next;
                place_reg <= place_next;
                marker_count_reg <= marker_count_next;
                prev_marker_reg <= prev_marker_next;
                bad_seen_reg <= bad_seen_next;
                good_frame_reg <= good_frame_next;
                good_time_reg <= good_time_next;
                ring_reg <= ring_next;
                slot_reg <= slot_next;
                fail_count_reg <= fail_count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pulse_accept)
        begin
            pulse_reg <= pulse;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

// File: design/tcpfd_checker.sv
// Port-level checks for the time code pulse frame decoder, bound to its top level.
module tcpfd_checker (
    input logic clk,
    input logic rst_n,
    input logic pulse_stall,
    input logic result_valid,
    input logic result_stall,
    input tcpfd_pkg::result_t result
);
    import tcpfd_pkg::*;

    // Hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed or dropped");

    // Stall pulses only while a result is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_stall |-> result_valid && result_stall)
        else $error("pulse stalled without a stalled result");

    // A good frame goes with a boundary symbol and the reverse
    a_frame_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.frame_valid == (result.symbol == SYM_BOUNDARY)))
        else $error("frame_valid and boundary symbol disagree");

    // A closed frame never also resynchronizes
    a_no_resync_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_valid |-> !result.resync)
        else $error("resync reported on a good frame");

endmodule

bind time_code_pulse_frame_decoder_unit tcpfd_checker u_tcpfd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .pulse_stall(pulse_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
);

// File: test/tb_time_code_pulse_frame_decoder_unit.sv
// Self-checking testbench for the time code pulse frame decoder top level.
`timescale 1ns / 1ps

module tb_time_code_pulse_frame_decoder_unit;
    import tcpfd_pkg::*;

    localparam int HIST_DEPTH = DEFAULT_HISTORY_DEPTH;
    localparam int FRAME_LEN = DEFAULT_FRAME_BITS;
    // Result register sits behind the input register; leave some margin.
    localparam int SETTLE_CYCLES = 8;
    // Receiver hold-off long enough to fill both internal registers and stall input.
    localparam int LONG_HOLD = 80;
    // Longest correct quiet stretch is the long hold plus a sender gap; allow far more.
    localparam int QUIET_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pulse_valid = 1'b0;
    logic pulse_stall;
    pulse_t pulse = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SHORT_LIMIT;
    logic [LIMIT_W-1:0] cfg_data = '0;

    time_code_pulse_frame_decoder_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pulse_valid(pulse_valid),
        .pulse_stall(pulse_stall),
        .pulse(pulse),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder shadow: limits, frame assembly state and outcome history.
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] lim_short;
    logic [LIMIT_W-1:0] lim_zero;
    logic [LIMIT_W-1:0] lim_one;
    logic [LIMIT_W-1:0] lim_marker;

    logic [63:0] frame_shift;
    int unsigned bit_pos;
    logic [5:0] markers_seen;
    bit last_was_marker;
    logic [5:0] bit_errors;
    logic [63:0] last_good_frame;
    logic [31:0] last_good_time;
    bit outcome_hist [HIST_DEPTH];
    int unsigned hist_slot;

    // Stimulus and scoreboard bookkeeping.
    pulse_t pending_pulses[$];
    result_t predicted_results[$];
    int items_queued = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int frames_closed = 0;
    int resyncs_seen = 0;
    int settings_run = 0;
    int errors = 0;
    int quiet_cycles = 0;
    bit beat_taken = 1'b0;

    // Traffic shaping shared between the stimulus thread and the two drivers.
    bit calm = 1'b0;
    int hold_requests = 0;
    int holds_done = 0;
    int idle_left = 0;
    int stall_left = 0;
    int hold_left = 0;

    task automatic clear_frame();
        frame_shift = '0;
        bit_pos = 1;
        markers_seen = '0;
        last_was_marker = 1'b0;
        bit_errors = '0;
    endtask

    task automatic reset_model();
        lim_short = SHORT_LIMIT_RESET;
        lim_zero = ZERO_LIMIT_RESET;
        lim_one = ONE_LIMIT_RESET;
        lim_marker = MARKER_LIMIT_RESET;
        clear_frame();
        last_good_frame = '0;
        last_good_time = '0;
        for (int k = 0; k < HIST_DEPTH; k++)
            outcome_hist[k] = 1'b1;
        hist_slot = 0;
    endtask

    // Place one bit at the next frame position, first bit highest.
    task automatic shift_in(input bit b);
        if (bit_pos >= 1 && bit_pos <= 64)
            frame_shift[64 - bit_pos] = frame_shift[64 - bit_pos] | b;
        if (bit_pos < 255)
            bit_pos++;
    endtask

    task automatic log_outcome(input bit failed);
        if (hist_slot >= HIST_DEPTH)
            hist_slot = 0;
        outcome_hist[hist_slot] = failed;
        hist_slot++;
        if (hist_slot >= HIST_DEPTH)
            hist_slot = 0;
    endtask

    // Classify one pulse, advance the frame state and build the result it causes.
    task automatic decode_pulse(input pulse_t p, output result_t r);
        logic [31:0] width;
        symbol_t sym;
        bit closed;
        bit overrun;
        int fails;
        width = p.pulse_end - p.pulse_start;
        closed = 1'b0;
        overrun = 1'b0;
        // Limits are tried in order, so out-of-order limits let the first hit decide.
        if (width < lim_short || (width >= lim_one && width >= lim_zero &&
            width >= lim_short && width >= lim_marker))
        begin
            sym = SYM_ERROR;
            shift_in(1'b0);
            if (bit_errors != MARKER_COUNT_MAX)
                bit_errors++;
            last_was_marker = 1'b0;
        end
        else if (width < lim_zero)
        begin
            sym = SYM_ZERO;
            shift_in(1'b0);
            last_was_marker = 1'b0;
        end
        else if (width < lim_one)
        begin
            sym = SYM_ONE;
            shift_in(1'b1);
            last_was_marker = 1'b0;
        end
        else if (last_was_marker && markers_seen == NEEDED_MARKERS &&
                 bit_pos == FRAME_LEN && bit_errors == 0)
        begin
            sym = SYM_BOUNDARY;
            closed = 1'b1;
            last_good_time = p.pulse_start;
            last_good_frame = frame_shift;
            log_outcome(1'b0);
            clear_frame();
        end
        else
        begin
            sym = SYM_MARKER;
            shift_in(1'b0);
            if (markers_seen != MARKER_COUNT_MAX)
                markers_seen++;
            last_was_marker = 1'b1;
        end

        // Overrun: log a failure and drop the partial frame.
        if (bit_pos > FRAME_LEN)
        begin
            overrun = 1'b1;
            log_outcome(1'b1);
            clear_frame();
        end

        fails = 0;
        for (int k = 0; k < HIST_DEPTH; k++)
            fails += outcome_hist[k];
        if (fails > 15)
            fails = 15;

        frames_closed += closed;
        resyncs_seen += overrun;
        r.symbol = sym;
        r.frame_valid = closed;
        r.frame_bits = FRAME_OUT_W'(last_good_frame >> (64 - FRAME_LEN));
        r.frame_time = last_good_time;
        r.resync = overrun;
        r.failed_frames = FAILED_W'(fails);
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders. Widths are picked from the current limit setting.
    // ------------------------------------------------------------------
    task automatic push_pulse(input logic [31:0] start, input logic [31:0] width);
        pulse_t p;
        p.pulse_start = start;
        p.pulse_end = start + width;
        pending_pulses.push_back(p);
        items_queued++;
    endtask

    function automatic logic [31:0] span_width(input logic [LIMIT_W-1:0] lo,
                                               input logic [LIMIT_W-1:0] hi);
        int unsigned pick;
        pick = $urandom_range(3, 0);
        if (pick == 0)
            return lo;
        if (pick == 1)
            return hi - 1;
        return $urandom_range(hi - 1, lo);
    endfunction

    function automatic logic [31:0] noise_width();
        logic [31:0] lim;
        case ($urandom_range(3, 0))
            0: lim = lim_short;
            1: lim = lim_zero;
            2: lim = lim_one;
            default: lim = lim_marker;
        endcase
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return $urandom_range(16'hFFFF, 0);
            2: return lim + $urandom_range(2, 0) - 1;
            3: return $urandom_range(1200, 0);
            4: return 32'hFFFF_FFFF - $urandom_range(3, 0);
            default: return $urandom_range(3, 0);
        endcase
    endfunction

    // Only meaningful while the limits are strictly ordered.
    task automatic push_symbol(input symbol_t kind);
        logic [31:0] w;
        case (kind)
            SYM_ZERO: w = span_width(lim_short, lim_zero);
            SYM_ONE: w = span_width(lim_zero, lim_one);
            SYM_MARKER: w = span_width(lim_one, lim_marker);
            default:
            begin
                if (lim_short > 0 && $urandom_range(1, 0) == 1)
                    w = $urandom_range(lim_short - 1, 0);
                else if ($urandom_range(3, 0) == 0)
                    w = 32'h0001_0000 + $urandom();
                else
                    w = lim_marker + $urandom_range(3000, 0);
                if (w < lim_marker)
                    w = 32'hFFFF_FFFF;
            end
        endcase
        push_pulse($urandom(), w);
    endtask

    task automatic push_noise(input int count);
        for (int k = 0; k < count; k++)
            push_pulse($urandom(), noise_width());
    endtask

    // Every pulse takes a frame position except a boundary, which is itself the
    // last of the frame, so the decoder clears on every multiple of FRAME_LEN.
    task automatic align_frame();
        while (items_queued % FRAME_LEN != 0)
            push_pulse($urandom(), noise_width());
    endtask

    // One frame: position markers at 9, 19, .. 59, data bits elsewhere, and a
    // closing marker. A damaged frame gets one defect so it fails or overruns.
    task automatic send_frame(input bit damaged);
        symbol_t kinds [FRAME_LEN];
        int cut;
        int idx;
        cut = FRAME_LEN;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (i % 10 == 8 || i == FRAME_LEN - 1)
                kinds[i] = SYM_MARKER;
            else
                kinds[i] = ($urandom_range(1, 0) == 1) ? SYM_ONE : SYM_ZERO;
        end
        if (damaged)
        begin
            case ($urandom_range(4, 0))
                0: kinds[$urandom_range(FRAME_LEN - 1, 0)] = SYM_ERROR;
                1: kinds[10 * $urandom_range(5, 0) + 8] = SYM_ZERO;
                2:
                begin
                    idx = $urandom_range(FRAME_LEN - 3, 0);
                    kinds[idx] = (idx % 10 == 8) ? SYM_ONE : SYM_MARKER;
                end
                3: kinds[FRAME_LEN - 1] = SYM_ONE;
                default: cut = $urandom_range(FRAME_LEN - 1, 1);
            endcase
        end
        for (int i = 0; i < cut; i++)
            push_symbol(kinds[i]);
    endtask

    // Hold until every queued beat went in and every result came back.
    task automatic wait_drained();
        while (!(items_accepted == items_queued && predicted_results.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            CFG_SHORT_LIMIT: lim_short = value;
            CFG_ZERO_LIMIT: lim_zero = value;
            CFG_ONE_LIMIT: lim_one = value;
            default: lim_marker = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One limit setting: drain, reprogram, then queue mostly well-formed frames if the limits are ordered, else noise.
    task automatic run_setting(input int s, input int z, input int o, input int m,
                               input int blocks, input bit steady, input bit long_hold);
        bit framed;
        wait_drained();
        write_limit(CFG_SHORT_LIMIT, LIMIT_W'(s));
        write_limit(CFG_ZERO_LIMIT, LIMIT_W'(z));
        write_limit(CFG_ONE_LIMIT, LIMIT_W'(o));
        write_limit(CFG_MARKER_LIMIT, LIMIT_W'(m));
        framed = (s < z) && (z < o) && (o < m);
        calm = steady;
        if (long_hold)
            hold_requests++;
        for (int b = 0; b < blocks; b++)
        begin
            if (framed && $urandom_range(99, 0) < 75)
            begin
                align_frame();
                send_frame($urandom_range(99, 0) < 30);
            end
            else
                push_noise(($urandom_range(99, 0) < 80) ? FRAME_LEN : $urandom_range(59, 1));
        end
        settings_run++;
    endtask

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ------------------------------------------------------------------
    // Pulse driver: present the next beat at the falling edge, hold it while
    // stalled, and insert random gaps between beats.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            pulse_valid <= 1'b0;
        else if (!pulse_valid || beat_taken)
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                pulse_valid <= 1'b0;
            end
            else if (pending_pulses.size() > 0)
            begin
                pulse <= pending_pulses.pop_front();
                pulse_valid <= 1'b1;
                idle_left = calm ? 0 : pick_gap();
            end
            else
                pulse_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall runs, plus one long hold-off on request
    // that is counted here so the decoder fills up and stalls its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_requests != holds_done)
        begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(99, 0) < 25)
        begin
            stall_left = pick_gap();
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted pulse beat, check each result beat
    // against the oldest prediction, and track quiet cycles for the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        bit result_taken;
        beat_taken = rst_n && pulse_valid && !pulse_stall;
        result_taken = rst_n && result_valid && !result_stall;
        if (beat_taken)
        begin
            decode_pulse(pulse, want);
            predicted_results.push_back(want);
            items_accepted++;
        end
        if (result_taken)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %0h", $time, result);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("symbol", want.symbol, result.symbol);
                check_field("frame_valid", want.frame_valid, result.frame_valid);
                check_field("frame_bits", want.frame_bits, result.frame_bits);
                check_field("frame_time", want.frame_time, result.frame_time);
                check_field("resync", want.resync, result.resync);
                check_field("failed_frames", want.failed_frames, result.failed_frames);
                results_checked++;
            end
        end
        if (beat_taken || result_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog: drop the run if no beat moves for far too long.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int s;
        int z;
        int o;
        int m;
        reset_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset limits: width extremes, wrap-around of
        // the timestamps, both sides of every limit, and back-to-back markers
        // that cannot close a frame.
        push_pulse(32'h0000_0000, 32'h0000_0000);
        push_pulse(32'hFFFF_FFFF, 32'h0000_0000);
        push_pulse(32'h0000_0000, 32'hFFFF_FFFF);
        push_pulse(32'hFFFF_FFFF, 32'h0000_0001);
        push_pulse(32'hFFFF_FF00, 32'h0000_0200);
        push_pulse(32'hAAAA_AAAA, 32'hAAAA_AAAB);
        push_pulse(32'h5555_5555, 32'h0000_012C);
        push_pulse($urandom(), 32'd99);
        push_pulse($urandom(), 32'd100);
        push_pulse($urandom(), 32'd399);
        push_pulse($urandom(), 32'd400);
        push_pulse($urandom(), 32'd699);
        push_pulse($urandom(), 32'd700);
        push_pulse($urandom(), 32'd899);
        push_pulse($urandom(), 32'd900);
        push_pulse($urandom(), 32'd800);
        push_pulse($urandom(), 32'd800);
        push_pulse($urandom(), 32'd65535);
        push_pulse($urandom(), 32'd65536);
        push_pulse($urandom(), 32'h8000_0000);
        push_pulse($urandom(), 32'd250);
        push_pulse($urandom(), 32'd550);
        align_frame();
        send_frame(1'b0);
        settings_run++;

        // Reset limits written explicitly, then a hold-off with a custom setting.
        run_setting(100, 400, 700, 900, 2, 1'b0, 1'b0);
        run_setting(50, 300, 600, 850, 4, 1'b0, 1'b1);
        // Extremes: single-value zero and one bands, widest marker band.
        run_setting(0, 1, 2, 65535, 3, 1'b1, 1'b0);
        run_setting(0, 0, 0, 0, 1, 1'b0, 1'b0);
        run_setting(65535, 65535, 65535, 65535, 1, 1'b0, 1'b0);
        // Limits out of order: the first limit the width falls below decides.
        run_setting(700, 100, 900, 400, 3, 1'b0, 1'b0);
        for (int k = 0; k < 2; k++)
        begin
            s = $urandom_range(1000, 0);
            z = s + $urandom_range(2000, 1);
            o = z + $urandom_range(2000, 1);
            m = o + $urandom_range(2000, 1);
            run_setting(s, z, o, m, 3, 1'b0, 1'b0);
        end
        s = $urandom_range(16000, 0);
        z = s + $urandom_range(16000, 1);
        o = z + $urandom_range(16000, 1);
        m = o + $urandom_range(16000, 1);
        run_setting(s, z, o, m, 3, 1'b0, 1'b0);
        run_setting(100, 400, 700, 900, 3, 1'b0, 1'b0);

        wait_drained();
        $display("Covered %0d pulse beats over %0d limit settings, %0d results checked.",
                 items_accepted, settings_run, results_checked);
        $display("Saw %0d good frames closed and %0d overrun resyncs.",
                 frames_closed, resyncs_seen);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
